// ===== rtl/core/n_queens_backtrack_search_core_assert.svh =====
// Assertion macros for the N-queens search core.
// Clock i_clk and active-low reset i_rst_n must be visible where a macro is used.
`ifndef N_QUEENS_BACKTRACK_SEARCH_CORE_ASSERT_SVH
`define N_QUEENS_BACKTRACK_SEARCH_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define NQBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define NQBS_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/nqbs_pkg.sv =====
// Shared constants and controller/datapath interface types of the N-queens search core.
// No dependencies.
`default_nettype none

package nqbs_pkg;

    localparam int MAX_SIZE   = 16;
    localparam int SIZE_W     = 5;
    localparam int ROW_W      = 4;
    localparam int DIAG_W     = 2 * MAX_SIZE - 1;
    localparam int COUNT_W    = 24;
    localparam int PLACE_W    = MAX_SIZE * ROW_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SIZE_W-1:0]     SIZE_RESET  = 5'd8;
    localparam logic [APB_ADDR_W-1:0] ADDR_BOARD  = 3'd0;

    typedef struct packed {
        logic clear;      // wipe marks, depth, placement and count
        logic step;       // visit one node of the search tree
        logic emit_miss;  // load a not-found result
    } t_dp_cmd;

    typedef struct packed {
        logic at_solution; // every column holds a queen
        logic exhausted;   // no rows left at column zero
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/nqbs_ctrl.sv =====
// Controller of the N-queens search core: request handshake, search phase, result strobe.
// Depends on nqbs_pkg.
`default_nettype none

module nqbs_ctrl
    import nqbs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_restart,
    input  wire logic       i_cfg_write,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SEARCH
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_DONE
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic   r_valid;
    logic   accept;

    assign accept          = i_start && (r_state == S_IDLE);
    assign o_cmd.clear     = accept && (i_restart || (r_phase == PH_IDLE));
    assign o_cmd.emit_miss = accept && !o_cmd.clear && (r_phase == PH_DONE);
    assign o_cmd.step      = (r_state == S_SEARCH);
    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (o_cmd.clear) begin
                            r_phase <= PH_RUN;
                            r_state <= S_SEARCH;
                        end else if (r_phase == PH_DONE) begin
                            r_valid <= 1'b1;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (i_status.at_solution) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (i_status.exhausted) begin
                        r_valid <= 1'b1;
                        r_phase <= PH_DONE;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // a new board size forgets the search
            if (i_cfg_write) begin
                r_phase <= PH_IDLE;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nqbs_dp.sv =====
// Datapath of the N-queens search core: occupancy masks, depth, trial row, placement, count.
// Depends on nqbs_pkg.
`default_nettype none

module nqbs_dp
    import nqbs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [SIZE_W-1:0]   i_size,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_status               o_status,
    output logic                     o_found,
    output logic [COUNT_W-1:0]       o_solution_number,
    output logic [PLACE_W-1:0]       o_placement
);

    logic [MAX_SIZE-1:0] r_row_taken;
    logic [DIAG_W-1:0]   r_rise_taken;
    logic [DIAG_W-1:0]   r_fall_taken;
    logic [SIZE_W-1:0]   r_depth;
    logic [SIZE_W-1:0]   r_row;
    logic [PLACE_W-1:0]  r_place;
    logic [COUNT_W-1:0]  r_count;
    logic                r_found;
    logic [COUNT_W-1:0]  r_out_number;
    logic [PLACE_W-1:0]  r_out_place;

    logic [ROW_W-1:0]    prev_col;
    logic [ROW_W-1:0]    prev_row;
    logic [SIZE_W-1:0]   prev_rise;
    logic [SIZE_W:0]     prev_fall_sum;
    logic [ROW_W-1:0]    cur_col;
    logic [ROW_W-1:0]    cur_row;
    logic [SIZE_W-1:0]   cur_rise;
    logic [SIZE_W:0]     cur_fall_sum;
    logic                at_solution;
    logic                rows_spent;
    logic                backtrack;
    logic                exhausted;
    logic                is_free;
    logic [COUNT_W-1:0]  count_next;

    // the placement doubles as the row stack of the levels below the current one
    assign prev_col      = r_depth[ROW_W-1:0] - ROW_W'(1);
    assign prev_row      = r_place[{prev_col, 2'b00} +: ROW_W];
    assign prev_rise     = {1'b0, prev_row} + {1'b0, prev_col};
    assign prev_fall_sum = {2'b00, prev_col} + {1'b0, i_size} - (SIZE_W+1)'(1)
                           - {2'b00, prev_row};

    assign cur_col       = r_depth[ROW_W-1:0];
    assign cur_row       = r_row[ROW_W-1:0];
    assign cur_rise      = {1'b0, cur_row} + {1'b0, cur_col};
    assign cur_fall_sum  = {2'b00, cur_col} + {1'b0, i_size} - (SIZE_W+1)'(1)
                           - {2'b00, cur_row};

    assign at_solution = (r_depth == i_size);
    assign rows_spent  = (r_row >= i_size);
    assign exhausted   = !at_solution && rows_spent && (r_depth == '0);
    assign backtrack   = at_solution || (rows_spent && (r_depth != '0));
    assign is_free     = !r_row_taken[cur_row] && !r_rise_taken[cur_rise]
                         && !r_fall_taken[cur_fall_sum[SIZE_W-1:0]];
    assign count_next  = (r_count == '1) ? r_count : r_count + COUNT_W'(1);

    assign o_status.at_solution = i_cmd.step && at_solution;
    assign o_status.exhausted   = i_cmd.step && exhausted;
    assign o_found              = r_found;
    assign o_solution_number    = r_out_number;
    assign o_placement          = r_out_place;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_count <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.clear) begin
            r_row_taken  <= '0;
            r_rise_taken <= '0;
            r_fall_taken <= '0;
            r_depth      <= '0;
            r_row        <= '0;
            r_place      <= '0;
            r_count      <= '0;
        end else if (i_cmd.emit_miss) begin
            r_found      <= 1'b0;
            r_out_number <= r_count;
            r_out_place  <= '0;
        end else if (i_cmd.step) begin
            if (backtrack) begin
                // lift the queen of the previous column and try its next row
                r_row_taken[prev_row]                   <= 1'b0;
                r_rise_taken[prev_rise]                 <= 1'b0;
                r_fall_taken[prev_fall_sum[SIZE_W-1:0]] <= 1'b0;
                r_depth <= r_depth - SIZE_W'(1);
                r_row   <= {1'b0, prev_row} + SIZE_W'(1);
                if (at_solution) begin
                    r_count      <= count_next;
                    r_found      <= 1'b1;
                    r_out_number <= count_next;
                    r_out_place  <= r_place;
                end
            end else if (exhausted) begin
                r_found      <= 1'b0;
                r_out_number <= r_count;
                r_out_place  <= '0;
            end else if (is_free) begin
                r_row_taken[cur_row]                   <= 1'b1;
                r_rise_taken[cur_rise]                 <= 1'b1;
                r_fall_taken[cur_fall_sum[SIZE_W-1:0]] <= 1'b1;
                r_place[{cur_col, 2'b00} +: ROW_W]     <= cur_row;
                r_depth <= r_depth + SIZE_W'(1);
                r_row   <= '0;
            end else begin
                r_row <= r_row + SIZE_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/n_queens_backtrack_search_core.sv =====
// N-queens backtracking search core. A request tests one square or lifts one queen per cycle,
// and the result strobe follows the cycle that completes a board or empties column zero; a
// search that is already exhausted answers the cycle after the request. The core handles
// one request at a time and accepts a new one only while it is not busy.
// Reset (synchronous, active low): board size 8, search not started, count zero.
// Results cannot be stalled; the strobe lasts exactly one cycle.
`default_nettype none

module n_queens_backtrack_search_core
    import nqbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_restart,
    // result channel
    output logic                       o_valid,
    output logic                       o_found,
    output logic [COUNT_W-1:0]         o_solution_number,
    output logic [PLACE_W-1:0]         o_placement,
    // configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

`include "n_queens_backtrack_search_core_assert.svh"

    logic [SIZE_W-1:0] r_board_size;
    logic [SIZE_W-1:0] eff_size;
    logic              board_sel;
    logic              cfg_write;
    t_dp_cmd           cmd;
    t_dp_status        status;

    // Only the register-select bit of the address is decoded; byte offsets are ignored.
    assign board_sel = (paddr[APB_ADDR_W-1] == ADDR_BOARD[APB_ADDR_W-1]);
    assign cfg_write = psel && penable && pwrite && pready && board_sel;
    assign pready    = 1'b1;
    assign prdata    = board_sel ? {{(APB_DATA_W-SIZE_W){1'b0}}, r_board_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= SIZE_RESET;
        end else if (cfg_write) begin
            r_board_size <= pwdata[SIZE_W-1:0];
        end
    end

    // Clamp the board size: zero acts as one, anything above the maximum as the maximum.
    always_comb begin
        if (r_board_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (r_board_size > SIZE_W'(MAX_SIZE)) begin
            eff_size = SIZE_W'(MAX_SIZE);
        end else begin
            eff_size = r_board_size;
        end
    end

    // Controller: accept requests, track the search phase, time the result strobe.
    nqbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_restart   (i_restart),
        .i_cfg_write (cfg_write),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_valid     (o_valid)
    );

    // Datapath: masks, depth, trial row, placement and the result registers.
    nqbs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_size            (eff_size),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_found           (o_found),
        .o_solution_number (o_solution_number),
        .o_placement       (o_placement)
    );

    // An accepted request either starts a walk or answers in the very next cycle.
    `NQBS_ASSERT(a_accept_progress, (start && !busy) |=> (busy || o_valid), "request lost")
    // A not-found result carries an empty placement.
    `NQBS_ASSERT(a_miss_empty, (o_valid && !o_found) |-> (o_placement == '0), "miss placement")
    // A found result always carries a nonzero solution number.
    `NQBS_ASSERT(a_hit_numbered, (o_valid && o_found) |-> (o_solution_number != '0),
        "hit count zero")
    // The result strobe is never shown while a walk is still under way.
    `NQBS_NEVER(a_valid_idle, o_valid && busy, "result during search")

endmodule

`default_nettype wire

// ===== sim/n_queens_backtrack_search_core_tb.sv =====
// Self-checking testbench for n_queens_backtrack_search_core: request/strobe traffic
// plus APB board-size writes, checked against an in-bench backtracking predictor.
// Depends on nqbs_pkg and the core RTL only.
`timescale 1ns / 1ps

module n_queens_backtrack_search_core_tb;
    import nqbs_pkg::*;

    // Quiet cycles allowed before the run is declared hung. The slowest walk is the
    // first board at the clamped size of sixteen.
    localparam int QUIET_LIMIT = 2_000_000;
    localparam int REPORT_MAX  = 10;
    localparam logic [COUNT_W-1:0] COUNT_TOP = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        WALK_IDLE = 2'd0,
        WALK_RUN  = 2'd1,
        WALK_DONE = 2'd2
    } walk_phase_t;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] number;
        logic [PLACE_W-1:0] placement;
    } solution_t;

    // DUT-facing signals; every input that the bench drives is known from time zero
    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  start     = 1'b0;
    logic                  i_restart = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic                  busy;
    logic                  o_valid;
    logic                  o_found;
    logic [COUNT_W-1:0]    o_solution_number;
    logic [PLACE_W-1:0]    o_placement;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor copy of the search state
    logic [SIZE_W-1:0]  size_reg;
    logic [15:0]        rows_used;
    logic [31:0]        rise_used;
    logic [31:0]        fall_used;
    int                 col_row [0:MAX_SIZE];
    int                 col_depth;
    logic [PLACE_W-1:0] board_bits;
    logic [COUNT_W-1:0] solutions_seen;
    walk_phase_t        walk_phase;

    solution_t pending_solutions[$];
    int        mismatch_count;
    int        sender_idle_pct;
    int        quiet_cycles;

    n_queens_backtrack_search_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_restart         (i_restart),
        .o_valid           (o_valid),
        .o_found           (o_found),
        .o_solution_number (o_solution_number),
        .o_placement       (o_placement),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp the register into 1..MAX_SIZE: zero acts as one, oversize as the maximum.
    function automatic int active_size();
        int n;
        n = int'(size_reg);
        if (n < 1) n = 1;
        if (n > MAX_SIZE) n = MAX_SIZE;
        return n;
    endfunction

    function automatic void wipe_search();
        rows_used  = '0;
        rise_used  = '0;
        fall_used  = '0;
        for (int i = 0; i <= MAX_SIZE; i++) col_row[i] = 0;
        col_depth  = 0;
        board_bits = '0;
    endfunction

    // Set or clear the row, rising-diagonal and falling-diagonal marks of one queen.
    function automatic void mark_queen(int r, int c, int n, bit set_it);
        int rb;
        int ub;
        int fb;
        rb = r & 15;
        ub = (r + c) & 31;
        fb = (c + n - 1 - r) & 31;
        rows_used[rb] = set_it;
        rise_used[ub] = set_it;
        fall_used[fb] = set_it;
    endfunction

    function automatic bit square_free(int r, int c, int n);
        return !rows_used[r & 15] && !rise_used[(r + c) & 31]
            && !fall_used[(c + n - 1 - r) & 31];
    endfunction

    // Walk the tree until the next full board (1) or until column zero runs dry (0).
    function automatic bit walk_to_board(int n);
        int d;
        int r;
        while (1) begin
            d = col_depth;
            if (d > MAX_SIZE) return 1'b0;
            if (d == n) begin
                // lift the last queen so the following request resumes past it
                d--;
                col_depth = d;
                mark_queen(col_row[d], d, n, 1'b0);
                col_row[d]++;
                return 1'b1;
            end
            r = col_row[d];
            if (r >= n) begin
                if (d == 0) return 1'b0;
                d--;
                col_depth = d;
                mark_queen(col_row[d], d, n, 1'b0);
                col_row[d]++;
            end else if (square_free(r, d, n)) begin
                mark_queen(r, d, n, 1'b1);
                board_bits[4*d +: 4] = r[3:0];
                col_depth = d + 1;
                col_row[d + 1] = 0;
            end else begin
                col_row[d] = r + 1;
            end
        end
        return 1'b0;
    endfunction

    function automatic solution_t compute_next_solution(bit restart_bit);
        solution_t s;
        int n;
        n = active_size();
        // a next request before any start behaves like a restart
        if (restart_bit || walk_phase == WALK_IDLE) begin
            wipe_search();
            solutions_seen = '0;
            walk_phase = WALK_RUN;
        end
        if (walk_phase == WALK_RUN) begin
            if (walk_to_board(n)) begin
                if (solutions_seen != COUNT_TOP) solutions_seen++;
                s.found     = 1'b1;
                s.number    = solutions_seen;
                s.placement = board_bits;
                return s;
            end
            walk_phase = WALK_DONE;
        end
        // exhausted: keep the final count, zero placement
        s.found     = 1'b0;
        s.number    = solutions_seen;
        s.placement = '0;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Request and configuration drivers
    // ------------------------------------------------------------------

    // Send one request; return at the accepting edge with start still high.
    task automatic send_request(input bit restart_bit);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_restart <= restart_bit;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_solutions.push_back(compute_next_solution(restart_bit));
    endtask

    // Drop start and hold off until every outstanding result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_solutions.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the board-size register over APB while the core is idle.
    task automatic write_board(input int value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BOARD;
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // a write also returns the search to not started and clears the count
        size_reg       = value[SIZE_W-1:0];
        wipe_search();
        solutions_seen = '0;
        walk_phase     = WALK_IDLE;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each strobe against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        solution_t want;
        if (i_rst_n && o_valid) begin
            if (pending_solutions.size() == 0) begin
                if (mismatch_count < REPORT_MAX)
                    $display("%0t: result with no request waiting: found=%0b num=%0d place=%h",
                             $realtime, o_found, o_solution_number, o_placement);
                mismatch_count++;
            end else begin
                want = pending_solutions.pop_front();
                if (o_found !== want.found || o_solution_number !== want.number
                        || o_placement !== want.placement) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("%0t: mismatch found %0b/%0b num %0d/%0d place %h/%h",
                                 $realtime, want.found, o_found, want.number,
                                 o_solution_number, want.placement, o_placement);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: count edges at which neither a request nor a result moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("n_queens_backtrack_search_core_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset the size is eight; a next request before any start acts as start.
    task automatic test_default_size();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // One square: one board, then an exhausted answer that repeats.
    task automatic test_single_square();
        write_board(1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // Size zero acts as one.
    task automatic test_size_zero();
        write_board(0);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Sizes two and three have no boards: exhausted straight away with count zero.
    task automatic test_no_solutions();
        write_board(3);
        send_request(1'b0);
        send_request(1'b1);
        write_board(2);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // Four queens: both boards, exhaustion, restart; a rewrite mid-search clears the count.
    task automatic test_four_queens();
        write_board(4);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        write_board(4);
        send_request(1'b0);
    endtask

    // All register bits set clamps to sixteen; sixteen itself sets the top bit alone.
    task automatic test_size_clamp();
        write_board(31);
        send_request(1'b1);
        send_request(1'b0);
        write_board(MAX_SIZE);
        send_request(1'b0);
    endtask

    // Random traffic: mostly next requests on small boards, with sporadic restarts,
    // bursts of restarts, and full drains so the sender waits on every result.
    task automatic test_random_traffic(input int idle_pct, input int item_count);
        int sent;
        int seg_len;
        int sz;
        int restart_pct;
        sender_idle_pct = idle_pct;
        sent = 0;
        while (sent < item_count) begin
            sz = ($urandom_range(3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
            write_board(sz);
            seg_len     = $urandom_range(15, 50);
            restart_pct = ($urandom_range(4) == 0) ? 40 : 6;
            for (int i = 0; i < seg_len && sent < item_count; i++) begin
                send_request($urandom_range(99) < restart_pct);
                sent++;
                if ($urandom_range(99) < 3) drain_results();
            end
        end
    endtask

    initial begin
        mismatch_count  = 0;
        sender_idle_pct = 0;
        size_reg        = SIZE_RESET;
        wipe_search();
        solutions_seen  = '0;
        walk_phase      = WALK_IDLE;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_default_size();
        test_single_square();
        test_size_zero();
        test_no_solutions();
        test_four_queens();
        test_size_clamp();
        test_random_traffic(38, 200);
        test_random_traffic(54, 200);
        test_random_traffic(0, 200);

        // Drain and allow the last strobe to settle
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_solutions.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && pending_solutions.size() == 0) begin
            $display("n_queens_backtrack_search_core_tb passed");
        end else begin
            $display("n_queens_backtrack_search_core_tb failed");
        end
        $finish;
    end

endmodule
